// ===== rtl/slider_filter_mode_controller_defines.svh =====
// Assertion helpers for the checker file of this block.
`ifndef SLIDER_FILTER_MODE_CONTROLLER_DEFINES_SVH
`define SLIDER_FILTER_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SFMC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfmc check failed");

// Next-cycle implication, disabled while reset is held.
`define SFMC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfmc check failed");

`endif

// ===== rtl/sfmc_pkg.sv =====
package sfmc_pkg;

  // Field widths.
  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = 2;
  localparam int SAMPLE_W     = 10;
  localparam int LEVEL_W      = 10;
  localparam int FRAC_W       = 16;
  localparam int FILT_W       = LEVEL_W + FRAC_W;
  localparam int TIME_W       = 32;
  localparam int STEP_W       = 4;
  localparam int PCT_W        = 7;
  localparam int THR_W        = 10;
  localparam int DELAY_W      = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int BOOT_LEN_W   = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANIM_DELAY = 1'd1;

  // Register reset values.
  localparam logic [THR_W-1:0]   THRESHOLD_RESET  = 10'd8;
  localparam logic [DELAY_W-1:0] ANIM_DELAY_RESET = 16'd50;

  // Filter coefficients: 0.9 and 0.1 scaled by 2^16.
  localparam int COEF_OLD_W = 16;
  localparam int COEF_NEW_W = 13;
  localparam logic [COEF_OLD_W-1:0] COEF_OLD = 16'd58982;
  localparam logic [COEF_NEW_W-1:0] COEF_NEW = 13'd6554;

  // Mode machine constants.
  localparam logic [STEP_W-1:0] BOOT_STEPS     = 4'd13;
  localparam logic [STEP_W-1:0] BOOT_SHOW_STEP = 4'd12;
  localparam logic [CH_W-1:0]   MASTER_CH      = 2'd3;
  localparam logic [TIME_W-1:0] CHANGED_TIMEOUT_MS = 32'd4000;
  localparam logic [TIME_W-1:0] MASTER_HOLD_MS     = 32'd3000;
  localparam logic [PCT_W-1:0]  PCT_MAX            = 7'd100;

  // Result queue depth.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  typedef enum logic [1:0] {
    MODE_BOOT    = 2'd0,
    MODE_MASTER  = 2'd1,
    MODE_CHANGED = 2'd2,
    MODE_IDLE    = 2'd3
  } mode_t;

  // One filtered sample handed from the filter stage to the scan controller.
  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [LEVEL_W-1:0] level;
    logic               priming;
    logic               last;
    logic [TIME_W-1:0]  now;
  } filt_item_t;

  // One scan result waiting in the queue for the percent stage.
  typedef struct packed {
    mode_t              mode;
    logic [STEP_W-1:0]  step;
    logic               shown;
    logic [CH_W-1:0]    ch;
    logic [LEVEL_W-1:0] level;
    logic               tick;
  } scan_result_t;

  // Duration of each boot step in milliseconds.
  function automatic logic [BOOT_LEN_W-1:0] boot_len(input logic [STEP_W-1:0] step);
    logic [BOOT_LEN_W-1:0] len;
    case (step) inside
      [4'd0:4'd7]:        len = 12'd800;
      4'd8:               len = 12'd1000;
      4'd9, 4'd10, 4'd11: len = 12'd500;
      default:            len = 12'd3000;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/sfmc_if.sv =====
// Sample channel: one slider reading per transaction.
interface sfmc_sample_if;
  logic                           valid;
  logic                           ready;
  logic [sfmc_pkg::CH_W-1:0]      channel;
  logic [sfmc_pkg::SAMPLE_W-1:0]  sample;
  logic                           last_of_scan;
  logic [sfmc_pkg::TIME_W-1:0]    now_ms;

  modport source (output valid, channel, sample, last_of_scan, now_ms, input ready);
  modport sink   (input valid, channel, sample, last_of_scan, now_ms, output ready);
endinterface

// Result channel: one display state per completed scan.
interface sfmc_result_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic [sfmc_pkg::STEP_W-1:0]  boot_step;
  logic                         shown_valid;
  logic [sfmc_pkg::CH_W-1:0]    shown_channel;
  logic [sfmc_pkg::PCT_W-1:0]   shown_percent;
  logic                         anim_tick;

  modport source (output valid, mode, boot_step, shown_valid, shown_channel, shown_percent,
                  anim_tick, input ready);
  modport sink   (input valid, mode, boot_step, shown_valid, shown_channel, shown_percent,
                  anim_tick, output ready);
endinterface

// ===== rtl/sfmc_filter.sv =====
module sfmc_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [sfmc_pkg::CH_W-1:0]     ch,
  input  logic [sfmc_pkg::SAMPLE_W-1:0] sample,
  input  logic                          last,
  input  logic [sfmc_pkg::TIME_W-1:0]   now,
  input  logic                          take,
  output logic                          item_valid,
  output sfmc_pkg::filt_item_t          item
);

  localparam int PROD_OLD_W = sfmc_pkg::FILT_W + sfmc_pkg::COEF_OLD_W;
  localparam int PROD_NEW_W = sfmc_pkg::SAMPLE_W + sfmc_pkg::COEF_NEW_W;

  logic [sfmc_pkg::FILT_W-1:0] filt [sfmc_pkg::NUM_CHANNELS];
  logic                        primed;
  logic [sfmc_pkg::FILT_W-1:0] f_old;
  logic [PROD_OLD_W-1:0]       prod_old;
  logic [PROD_NEW_W-1:0]       prod_new;
  logic [sfmc_pkg::FILT_W-1:0] filt_next;

  // Exponential filter: 0.9 of the old level plus 0.1 of the sample, truncated once.
  assign f_old    = filt[ch];
  assign prod_old = {{sfmc_pkg::COEF_OLD_W{1'b0}}, f_old}
                  * {{sfmc_pkg::FILT_W{1'b0}}, sfmc_pkg::COEF_OLD};
  assign prod_new = {{sfmc_pkg::COEF_NEW_W{1'b0}}, sample}
                  * {{sfmc_pkg::SAMPLE_W{1'b0}}, sfmc_pkg::COEF_NEW};

  // The priming scan loads the sample directly.
  always_comb begin
    if (!primed) begin
      filt_next = {sample, {sfmc_pkg::FRAC_W{1'b0}}};
    end else begin
      filt_next = prod_old[PROD_OLD_W-1:sfmc_pkg::FRAC_W]
                + {{(sfmc_pkg::FILT_W-PROD_NEW_W){1'b0}}, prod_new};
    end
  end

  // Filter state and the stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      primed     <= 1'b0;
      for (int i = 0; i < sfmc_pkg::NUM_CHANNELS; i++) begin
        filt[i] <= '0;
      end
    end else begin
      item_valid <= accept || (item_valid && !take);
      if (accept) begin
        filt[ch] <= filt_next;
        if (last) begin
          primed <= 1'b1;
        end
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      item.ch      <= ch;
      item.level   <= filt_next[sfmc_pkg::FILT_W-1:sfmc_pkg::FRAC_W];
      item.priming <= !primed;
      item.last    <= last;
      item.now     <= now;
    end
  end

endmodule

// ===== rtl/sfmc_scan_ctrl.sv =====
module sfmc_scan_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sfmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfmc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           item_valid,
  input  sfmc_pkg::filt_item_t           item,
  input  logic                           fifo_full,
  output logic                           take,
  output logic                           push,
  output sfmc_pkg::scan_result_t         push_data
);

  logic [sfmc_pkg::LEVEL_W-1:0] reported  [sfmc_pkg::NUM_CHANNELS];
  logic [sfmc_pkg::LEVEL_W-1:0] level_now [sfmc_pkg::NUM_CHANNELS];
  logic [sfmc_pkg::LEVEL_W-1:0] level_next[sfmc_pkg::NUM_CHANNELS];
  logic                         scan_changed;
  logic [sfmc_pkg::CH_W-1:0]    chg_idx;
  logic                         chg_valid;
  sfmc_pkg::mode_t              mode;
  logic [sfmc_pkg::STEP_W-1:0]  step;
  logic [sfmc_pkg::TIME_W-1:0]  boot_mark;
  logic [sfmc_pkg::TIME_W-1:0]  act_mark;
  logic [sfmc_pkg::TIME_W-1:0]  anim_mark;
  logic [sfmc_pkg::THR_W-1:0]   threshold;
  logic [sfmc_pkg::DELAY_W-1:0] anim_delay;

  logic                         closing;
  logic [sfmc_pkg::LEVEL_W-1:0] rep_old;
  logic [sfmc_pkg::LEVEL_W-1:0] diff;
  logic                         hit;
  logic                         sc;
  logic [sfmc_pkg::CH_W-1:0]    chg_idx_next;
  logic                         chg_valid_next;
  logic [sfmc_pkg::TIME_W-1:0]  el_boot;
  logic [sfmc_pkg::TIME_W-1:0]  el_act;
  logic [sfmc_pkg::TIME_W-1:0]  el_anim;
  sfmc_pkg::mode_t              mode_a;
  sfmc_pkg::mode_t              mode_next;
  logic [sfmc_pkg::STEP_W-1:0]  step_next;
  logic [sfmc_pkg::TIME_W-1:0]  boot_mark_next;
  logic [sfmc_pkg::TIME_W-1:0]  act_mark_next;
  logic [sfmc_pkg::TIME_W-1:0]  anim_mark_next;
  logic                         shown;
  logic [sfmc_pkg::CH_W-1:0]    shown_ch;
  logic [sfmc_pkg::LEVEL_W-1:0] shown_level;
  logic                         tick;

  // A closing transaction of a primed scan needs a queue slot.
  assign closing = item.last && !item.priming;
  assign take    = item_valid && !(closing && fifo_full);
  assign push    = take && closing;

  // Movement detection against the last reported value, off while booting.
  assign rep_old = reported[item.ch];
  assign diff    = (item.level > rep_old) ? (item.level - rep_old) : (rep_old - item.level);
  assign hit     = !item.priming && (mode != sfmc_pkg::MODE_BOOT) && (diff > threshold);
  assign sc      = scan_changed || hit;
  assign chg_idx_next   = hit ? item.ch : chg_idx;
  assign chg_valid_next = chg_valid || hit;

  // Elapsed times since each mark.
  assign el_boot = item.now - boot_mark;
  assign el_act  = item.now - act_mark;
  assign el_anim = item.now - anim_mark;

  // Channel values including this transaction's update.
  always_comb begin
    for (int i = 0; i < sfmc_pkg::NUM_CHANNELS; i++) begin
      level_next[i] = level_now[i];
    end
    level_next[item.ch] = item.level;
  end

  // End-of-scan mode machine.
  always_comb begin
    mode_a         = mode;
    step_next      = step;
    boot_mark_next = boot_mark;
    act_mark_next  = act_mark;
    anim_mark_next = anim_mark;
    shown          = 1'b0;
    shown_ch       = '0;
    shown_level    = '0;
    tick           = 1'b0;

    // Movement restarts the changed display; a quiet changed display times out.
    if (sc) begin
      act_mark_next = item.now;
      mode_a        = sfmc_pkg::MODE_CHANGED;
    end else if (mode == sfmc_pkg::MODE_CHANGED && el_act > sfmc_pkg::CHANGED_TIMEOUT_MS) begin
      mode_a         = sfmc_pkg::MODE_IDLE;
      anim_mark_next = item.now;
    end
    mode_next = mode_a;

    unique case (mode_a)
      sfmc_pkg::MODE_BOOT: begin
        if (step < sfmc_pkg::BOOT_STEPS &&
            el_boot >= {{(sfmc_pkg::TIME_W-sfmc_pkg::BOOT_LEN_W){1'b0}},
                        sfmc_pkg::boot_len(step)}) begin
          step_next      = step + 4'd1;
          boot_mark_next = item.now;
        end
        if (step_next == sfmc_pkg::BOOT_SHOW_STEP) begin
          shown       = 1'b1;
          shown_ch    = sfmc_pkg::MASTER_CH;
          shown_level = level_next[sfmc_pkg::MASTER_CH];
        end else if (step_next >= sfmc_pkg::BOOT_STEPS) begin
          mode_next     = sfmc_pkg::MODE_MASTER;
          act_mark_next = item.now;
        end
      end
      sfmc_pkg::MODE_MASTER: begin
        shown       = 1'b1;
        shown_ch    = sfmc_pkg::MASTER_CH;
        shown_level = level_next[sfmc_pkg::MASTER_CH];
        if (el_act >= sfmc_pkg::MASTER_HOLD_MS) begin
          mode_next      = sfmc_pkg::MODE_IDLE;
          anim_mark_next = item.now;
        end
      end
      sfmc_pkg::MODE_CHANGED: begin
        if (chg_valid_next) begin
          shown       = 1'b1;
          shown_ch    = chg_idx_next;
          shown_level = level_next[chg_idx_next];
        end
      end
      sfmc_pkg::MODE_IDLE: begin
        // Entering idle in this scan sets the mark to now, so no tick then.
        if (mode == sfmc_pkg::MODE_IDLE &&
            el_anim > {{(sfmc_pkg::TIME_W-sfmc_pkg::DELAY_W){1'b0}}, anim_delay}) begin
          anim_mark_next = item.now;
          tick           = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign push_data.mode  = mode_next;
  assign push_data.step  = step_next;
  assign push_data.shown = shown;
  assign push_data.ch    = shown_ch;
  assign push_data.level = shown_level;
  assign push_data.tick  = tick;

  // Controller state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_changed <= 1'b0;
      chg_idx      <= '0;
      chg_valid    <= 1'b0;
      mode         <= sfmc_pkg::MODE_BOOT;
      step         <= '0;
      boot_mark    <= '0;
      act_mark     <= '0;
      anim_mark    <= '0;
      threshold    <= sfmc_pkg::THRESHOLD_RESET;
      anim_delay   <= sfmc_pkg::ANIM_DELAY_RESET;
      for (int i = 0; i < sfmc_pkg::NUM_CHANNELS; i++) begin
        reported[i]  <= '0;
        level_now[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sfmc_pkg::CFG_THRESHOLD:  threshold  <= cfg_data[sfmc_pkg::THR_W-1:0];
          sfmc_pkg::CFG_ANIM_DELAY: anim_delay <= cfg_data[sfmc_pkg::DELAY_W-1:0];
          default: begin
          end
        endcase
      end
      if (take) begin
        level_now[item.ch] <= item.level;
        chg_idx            <= chg_idx_next;
        chg_valid          <= chg_valid_next;
        if (item.priming || hit) begin
          reported[item.ch] <= item.level;
        end
        if (item.last && item.priming) begin
          boot_mark <= item.now;
        end else if (item.last) begin
          scan_changed <= 1'b0;
          mode         <= mode_next;
          step         <= step_next;
          boot_mark    <= boot_mark_next;
          act_mark     <= act_mark_next;
          anim_mark    <= anim_mark_next;
        end else begin
          scan_changed <= sc;
        end
      end
    end
  end

endmodule

// ===== rtl/sfmc_queue.sv =====
module sfmc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sfmc_pkg::scan_result_t push_data,
  input  logic                   pop,
  output sfmc_pkg::scan_result_t head,
  output logic                   empty,
  output logic                   full
);

  sfmc_pkg::scan_result_t         mem [sfmc_pkg::FIFO_DEPTH];
  logic [sfmc_pkg::PTR_W-1:0]     wr_ptr;
  logic [sfmc_pkg::PTR_W-1:0]     rd_ptr;
  logic [sfmc_pkg::CNT_W-1:0]     count;

  assign empty = (count == '0);
  assign full  = (count == sfmc_pkg::CNT_W'(sfmc_pkg::FIFO_DEPTH));
  assign head  = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sfmc_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sfmc_pkg::PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + sfmc_pkg::CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - sfmc_pkg::CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/sfmc_percent.sv =====
module sfmc_percent (
  input  logic                         clk,
  input  logic                         rst,
  input  sfmc_pkg::scan_result_t       head,
  input  logic                         empty,
  output logic                         pop,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [1:0]                   mode,
  output logic [sfmc_pkg::STEP_W-1:0]  boot_step,
  output logic                         shown_valid,
  output logic [sfmc_pkg::CH_W-1:0]    shown_channel,
  output logic [sfmc_pkg::PCT_W-1:0]   shown_percent,
  output logic                         anim_tick
);

  localparam int X_W = 17;

  logic [X_W-1:0]            scaled;
  logic [X_W-1:0]            q_sum;
  logic [sfmc_pkg::PCT_W-1:0] pct;

  // Refill the output register when it is empty or being taken.
  assign pop = !empty && (!out_valid || out_ready);

  // (level*100 + 511) / 1023, dividing by 2^10-1 with the add-back trick.
  assign scaled = {{(X_W-sfmc_pkg::LEVEL_W){1'b0}}, head.level} * 17'd100 + 17'd511;
  assign q_sum  = scaled + (scaled >> 10) + 17'd1;
  assign pct    = q_sum[16:10];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (pop) begin
      mode          <= head.mode;
      boot_step     <= head.step;
      shown_valid   <= head.shown;
      shown_channel <= head.shown ? head.ch : '0;
      shown_percent <= head.shown ? pct : '0;
      anim_tick     <= head.tick;
    end
  end

endmodule

// ===== rtl/slider_filter_mode_controller.sv =====
// Slider filter and display mode controller.
// Samples arrive on the samples channel, one slider reading per transaction, with
// last_of_scan marking the final channel of a scan. Every sample is smoothed by a
// 0.9/0.1 exponential filter; each closing transaction of a scan runs movement
// detection and the display mode machine and yields one transaction on the results
// channel. The first scan after reset only primes the filters and yields nothing.
// Configuration is written through cfg_we/cfg_index/cfg_data: index 0 is the
// change threshold, index 1 the idle animation delay in milliseconds.
// Throughput is one sample per clock unless the front holds back. A result is loaded
// in turn into the filter stage register, a result queue entry and the percent output
// register, and it turns valid once that output register holds it.
// A four-entry result queue separates the front from the output register, so the
// front keeps taking samples while the receiver stalls; it holds back only when
// the queue is full and a closing sample waits for a slot.
// Synchronous reset clears the filters, the mode machine and the queue, and
// restores both configuration registers to their defaults.
module slider_filter_mode_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sfmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfmc_pkg::CFG_W-1:0]     cfg_data,
  sfmc_sample_if.sink                    samples,
  sfmc_result_if.source                  results
);

  logic                   accept;
  logic                   take;
  logic                   item_valid;
  sfmc_pkg::filt_item_t   item;
  logic                   push;
  sfmc_pkg::scan_result_t push_data;
  logic                   pop;
  sfmc_pkg::scan_result_t head;
  logic                   empty;
  logic                   full;

  // The filter stage moves on when it is empty or its item goes forward.
  assign samples.ready = !item_valid || take;
  assign accept        = samples.valid && samples.ready;

  sfmc_filter u_filter (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .ch         (samples.channel),
    .sample     (samples.sample),
    .last       (samples.last_of_scan),
    .now        (samples.now_ms),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  sfmc_scan_ctrl u_scan_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .fifo_full  (full),
    .take       (take),
    .push       (push),
    .push_data  (push_data)
  );

  sfmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  sfmc_percent u_percent (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_ready     (results.ready),
    .out_valid     (results.valid),
    .mode          (results.mode),
    .boot_step     (results.boot_step),
    .shown_valid   (results.shown_valid),
    .shown_channel (results.shown_channel),
    .shown_percent (results.shown_percent),
    .anim_tick     (results.anim_tick)
  );

endmodule

// ===== rtl/sfmc_checker.sv =====
`include "slider_filter_mode_controller_defines.svh"

module sfmc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   mode,
  input logic [sfmc_pkg::STEP_W-1:0]  boot_step,
  input logic                         shown_valid,
  input logic [sfmc_pkg::CH_W-1:0]    shown_channel,
  input logic [sfmc_pkg::PCT_W-1:0]   shown_percent,
  input logic                         anim_tick
);

  // A stalled result keeps its mode and percent.
  `SFMC_ASSERT_NXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(mode) && $stable(shown_percent))

  // Animation ticks only come from the idle mode.
  `SFMC_ASSERT_IMP(a_tick_idle, clk, rst, out_valid && anim_tick, mode == sfmc_pkg::MODE_IDLE)

  // Booting exactly while the boot sequence is unfinished.
  `SFMC_ASSERT_IMP(a_boot_step, clk, rst, out_valid, (mode == sfmc_pkg::MODE_BOOT) == (boot_step < sfmc_pkg::BOOT_STEPS))

  // Nothing shown means zero channel and percent.
  `SFMC_ASSERT_IMP(a_hidden_zero, clk, rst, out_valid && !shown_valid, shown_channel == 2'd0 && shown_percent == 7'd0)

  // The percentage never exceeds full scale.
  `SFMC_ASSERT_IMP(a_pct_range, clk, rst, out_valid, shown_percent <= sfmc_pkg::PCT_MAX)

endmodule

bind slider_filter_mode_controller sfmc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .mode          (results.mode),
  .boot_step     (results.boot_step),
  .shown_valid   (results.shown_valid),
  .shown_channel (results.shown_channel),
  .shown_percent (results.shown_percent),
  .anim_tick     (results.anim_tick)
);

// ===== dv/sfmc_display_checker.sv =====
`timescale 1ns / 1ps

// Watches the sample and result channels, predicts the display state for every
// closing sample transaction and compares each result transaction against it.
module sfmc_display_checker
  import sfmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  sfmc_sample_if               smp,
  sfmc_result_if               res,
  output int                   errors,
  output int                   pending,
  output int                   compared,
  output int                   ticks,
  output int                   shown
);

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    mode_t              mode;
    logic [STEP_W-1:0]  step;
    logic               show;
    logic [CH_W-1:0]    ch;
    logic [PCT_W-1:0]   pct;
    logic               tick;
  } display_t;

  // Display states predicted but not yet seen on the result channel.
  display_t want_display[$];

  // Predictor state.
  logic [FILT_W-1:0]  filt_lvl [NUM_CHANNELS];
  logic [LEVEL_W-1:0] rep_lvl  [NUM_CHANNELS];
  logic               primed;
  logic               scan_moved;
  logic               moved_ok;
  logic [CH_W-1:0]    moved_ch;
  mode_t              mode_now;
  logic [STEP_W-1:0]  boot_pos;
  logic [TIME_W-1:0]  boot_mark;
  logic [TIME_W-1:0]  activity_mark;
  logic [TIME_W-1:0]  anim_mark;
  logic [THR_W-1:0]   threshold;
  logic [DELAY_W-1:0] anim_delay;

  int fail_count;
  int compared_n;
  int tick_n;
  int shown_n;

  function automatic void clear_state();
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      filt_lvl[i] = '0;
      rep_lvl[i]  = '0;
    end
    primed        = 1'b0;
    scan_moved    = 1'b0;
    moved_ok      = 1'b0;
    moved_ch      = '0;
    mode_now      = MODE_BOOT;
    boot_pos      = '0;
    boot_mark     = '0;
    activity_mark = '0;
    anim_mark     = '0;
    threshold     = THRESHOLD_RESET;
    anim_delay    = ANIM_DELAY_RESET;
  endfunction

  // How long each boot step lasts before the next one starts.
  function automatic logic [TIME_W-1:0] boot_hold_ms(input logic [STEP_W-1:0] step);
    if (step < 8) return 32'd800;
    if (step == 8) return 32'd1000;
    if (step < BOOT_SHOW_STEP) return 32'd500;
    return 32'd3000;
  endfunction

  // Rounded percentage of a 10-bit level.
  function automatic logic [PCT_W-1:0] pct_of(input logic [LEVEL_W-1:0] v);
    int unsigned p;
    if (v == 0) return '0;
    if (v >= 10'd1023) return PCT_MAX;
    p = (32'(v) * 100 + 511) / 1023;
    return (p > 100) ? PCT_MAX : PCT_W'(p);
  endfunction

  // Filters one sample and, on a closing sample, steps the mode machine.
  // Returns 1 when the sample yields a display state.
  function automatic bit advance_controller(input logic [CH_W-1:0] ch,
                                            input logic [SAMPLE_W-1:0] raw,
                                            input logic last,
                                            input logic [TIME_W-1:0] now,
                                            output display_t d);
    logic [41:0]        prod;
    logic [FILT_W-1:0]  fl;
    logic [LEVEL_W-1:0] lvl;
    logic [LEVEL_W-1:0] lvl_diff;
    d = '0;
    if (!primed) begin
      filt_lvl[ch] = {raw, 16'd0};
      rep_lvl[ch]  = raw;
    end else begin
      prod = 42'(filt_lvl[ch]) * 42'(COEF_OLD);
      fl   = prod[41:16] + FILT_W'(raw) * FILT_W'(COEF_NEW);
      filt_lvl[ch] = fl;
      lvl = fl[FILT_W-1:FRAC_W];
      // Movement counts only once booting is over.
      if (mode_now != MODE_BOOT) begin
        lvl_diff = (lvl > rep_lvl[ch]) ? lvl - rep_lvl[ch] : rep_lvl[ch] - lvl;
        if (lvl_diff > threshold) begin
          rep_lvl[ch] = lvl;
          moved_ch    = ch;
          moved_ok    = 1'b1;
          scan_moved  = 1'b1;
        end
      end
    end

    if (!last) return 1'b0;

    // The first closing sample only starts the boot clock.
    if (!primed) begin
      primed    = 1'b1;
      boot_mark = now;
      return 1'b0;
    end

    if (scan_moved) begin
      activity_mark = now;
      mode_now      = MODE_CHANGED;
    end else if (mode_now == MODE_CHANGED && now - activity_mark > CHANGED_TIMEOUT_MS) begin
      mode_now  = MODE_IDLE;
      anim_mark = now;
    end
    scan_moved = 1'b0;

    case (mode_now)
      MODE_BOOT: begin
        if (boot_pos < BOOT_STEPS && now - boot_mark >= boot_hold_ms(boot_pos)) begin
          boot_pos  = boot_pos + STEP_W'(1);
          boot_mark = now;
        end
        if (boot_pos == BOOT_SHOW_STEP) begin
          d.show = 1'b1;
          d.ch   = MASTER_CH;
          d.pct  = pct_of(filt_lvl[MASTER_CH][FILT_W-1:FRAC_W]);
        end else if (boot_pos >= BOOT_STEPS) begin
          mode_now      = MODE_MASTER;
          activity_mark = now;
        end
      end
      MODE_MASTER: begin
        d.show = 1'b1;
        d.ch   = MASTER_CH;
        d.pct  = pct_of(filt_lvl[MASTER_CH][FILT_W-1:FRAC_W]);
        if (now - activity_mark >= MASTER_HOLD_MS) begin
          mode_now  = MODE_IDLE;
          anim_mark = now;
        end
      end
      MODE_CHANGED: begin
        if (moved_ok) begin
          d.show = 1'b1;
          d.ch   = moved_ch;
          d.pct  = pct_of(filt_lvl[moved_ch][FILT_W-1:FRAC_W]);
        end
      end
      default: begin
        if (now - anim_mark > TIME_W'(anim_delay)) begin
          anim_mark = now;
          d.tick    = 1'b1;
        end
      end
    endcase

    d.mode = mode_now;
    d.step = boot_pos;
    return 1'b1;
  endfunction

  // Prints one mismatch and counts it; printing stops after a cap.
  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= PRINT_CAP) $display("%0t ns: %s", $time, msg);
  endtask

  // Compares one result transaction with the oldest prediction.
  task automatic check_display();
    display_t want;
    if (want_display.size() == 0) begin
      report_mismatch("result transaction with no display state predicted");
      return;
    end
    want = want_display.pop_front();
    compared_n++;
    if (want.tick) tick_n++;
    if (want.show) shown_n++;
    if (res.mode != want.mode)
      report_mismatch($sformatf("mode: got %0d, expected %0d", res.mode, want.mode));
    if (res.boot_step != want.step)
      report_mismatch($sformatf("boot_step: got %0d, expected %0d", res.boot_step, want.step));
    if (res.shown_valid != want.show)
      report_mismatch($sformatf("shown_valid: got %0d, expected %0d",
                                res.shown_valid, want.show));
    if (res.shown_channel != want.ch)
      report_mismatch($sformatf("shown_channel: got %0d, expected %0d",
                                res.shown_channel, want.ch));
    if (res.shown_percent != want.pct)
      report_mismatch($sformatf("shown_percent: got %0d, expected %0d",
                                res.shown_percent, want.pct));
    if (res.anim_tick != want.tick)
      report_mismatch($sformatf("anim_tick: got %0d, expected %0d", res.anim_tick, want.tick));
  endtask

  // All channel activity is sampled at the rising edge.
  always @(posedge clk) begin
    display_t d;
    if (rst) begin
      clear_state();
      want_display.delete();
      fail_count = 0;
      compared_n = 0;
      tick_n     = 0;
      shown_n    = 0;
    end else begin
      if (res.valid && res.ready) check_display();
      if (cfg_we) begin
        if (cfg_index == CFG_THRESHOLD) threshold = cfg_data[THR_W-1:0];
        else if (cfg_index == CFG_ANIM_DELAY) anim_delay = cfg_data[DELAY_W-1:0];
      end
      if (smp.valid && smp.ready) begin
        if (advance_controller(smp.channel, smp.sample, smp.last_of_scan, smp.now_ms, d))
          want_display.push_back(d);
      end
    end
    pending  <= want_display.size();
    errors   <= fail_count;
    compared <= compared_n;
    ticks    <= tick_n;
    shown    <= shown_n;
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sfmc_pkg::*;

  localparam int IDLE_LIMIT    = 500;
  localparam int RANDOM_ITEMS  = 1630;
  localparam int NUM_SETTINGS  = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_WAIT      = 13;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  sfmc_sample_if smp ();
  sfmc_result_if res ();

  int errors;
  int pending;
  int compared;
  int ticks;
  int shown;

  int idle_cycles = 0;
  int rx_wait;
  int items_sent;
  int scans_sent;
  bit tx_burst;
  bit rx_burst;
  bit quiet;
  logic [TIME_W-1:0]   clock_ms;
  logic [SAMPLE_W-1:0] slider_pos [NUM_CHANNELS];

  slider_filter_mode_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (smp),
    .results   (res)
  );

  sfmc_display_checker i_display_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .smp       (smp),
    .res       (res),
    .errors    (errors),
    .pending   (pending),
    .compared  (compared),
    .ticks     (ticks),
    .shown     (shown)
  );

  // 250 MHz clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result receiver: after each transaction it stalls for a random number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      rx_wait = 0;
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (rx_wait != 0) begin
        rx_wait--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: no transaction for %0d cycles", IDLE_LIMIT);
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sends one sample transaction after a random gap and waits for its acceptance.
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] raw,
                             input logic last, input logic [TIME_W-1:0] now);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid        <= 1'b1;
    smp.channel      <= ch;
    smp.sample       <= raw;
    smp.last_of_scan <= last;
    smp.now_ms       <= now;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    items_sent++;
    if (last) scans_sent++;
  endtask

  // Holds the sample channel until every predicted result has arrived.
  task automatic wait_for_results();
    smp.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Writes both registers once the block has gone quiet.
  task automatic write_settings(input logic [THR_W-1:0] thr, input logic [DELAY_W-1:0] dly);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THRESHOLD;
    cfg_data  <= CFG_W'(thr);
    @(posedge clk);
    cfg_index <= CFG_ANIM_DELAY;
    cfg_data  <= dly;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A reading near the slider position; now and then pure noise.
  function automatic logic [SAMPLE_W-1:0] reading_of(input logic [CH_W-1:0] ch);
    int v;
    if ($urandom_range(0, 49) == 0) return SAMPLE_W'($urandom());
    v = int'(slider_pos[ch]);
    if (!quiet) v = v + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return SAMPLE_W'(v);
  endfunction

  // One scan: time moves on, sliders may move, then the samples go out.
  task automatic send_scan();
    int r;
    int n;
    logic [CH_W-1:0] ch;
    if ($urandom_range(0, 79) == 0) wait_for_results();
    if ($urandom_range(0, 24) == 0) tx_burst = !tx_burst;
    if ($urandom_range(0, 24) == 0) rx_burst = !rx_burst;
    if ($urandom_range(0, 9) == 0) quiet = !quiet;

    // Mostly short steps, sometimes long enough for the timeouts, rarely a huge jump.
    r = $urandom_range(0, 99);
    if (r < 70) clock_ms += $urandom_range(0, 120);
    else if (r < 97) clock_ms += $urandom_range(400, 4600);
    else clock_ms += $urandom();

    if (!quiet) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        r = $urandom_range(0, 23);
        if (r == 0) slider_pos[i] = '0;
        else if (r == 1) slider_pos[i] = '1;
        else if (r < 5) slider_pos[i] = SAMPLE_W'($urandom());
      end
    end

    if ($urandom_range(0, 99) < 85) begin
      // Well-formed scan over all channels in order.
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ch = CH_W'(i);
        send_sample(ch, reading_of(ch), i == NUM_CHANNELS - 1, clock_ms);
      end
    end else begin
      // Irregular scan: random length and channel order.
      n = $urandom_range(1, 7);
      for (int i = 0; i < n; i++) begin
        ch = CH_W'($urandom());
        send_sample(ch, reading_of(ch), i == n - 1,
                    (i == n - 1) ? clock_ms : TIME_W'($urandom()));
      end
    end
  endtask

  initial begin
    int base;
    logic [THR_W-1:0]   thr;
    logic [DELAY_W-1:0] dly;

    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CFG_THRESHOLD;
    cfg_data         = '0;
    smp.valid        = 1'b0;
    smp.channel      = '0;
    smp.sample       = '0;
    smp.last_of_scan = 1'b0;
    smp.now_ms       = '0;
    res.ready        = 1'b0;
    tx_burst         = 1'b0;
    rx_burst         = 1'b0;
    quiet            = 1'b0;
    items_sent       = 0;
    scans_sent       = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Priming scan with the sample extremes; the time field is unused on open samples.
    clock_ms = 32'hFFFF_F000;
    send_sample(2'd0, 10'd0, 1'b0, 32'hFFFF_FFFF);
    send_sample(2'd1, 10'd1023, 1'b0, 32'h0000_0000);
    send_sample(2'd2, 10'h2AA, 1'b0, 32'hAAAA_5555);
    send_sample(2'd3, 10'h155, 1'b1, clock_ms);

    // Boot sequence: one scan just short of the first step, then each step on its boundary.
    // The millisecond counter wraps during boot.
    send_sample(2'd3, 10'd1023, 1'b1, clock_ms + 32'd799);
    for (int s = 0; s < BOOT_STEPS; s++) begin
      clock_ms += (s < 8) ? 32'd800 : (s == 8) ? 32'd1000 : (s < 12) ? 32'd500 : 32'd3000;
      send_sample(2'd3, (s % 2 == 0) ? 10'd1023 : 10'd0, 1'b1, clock_ms);
    end

    // Show master once, then let it fall to idle.
    clock_ms += 32'd10;
    send_sample(2'd3, 10'd0, 1'b1, clock_ms);
    clock_ms += MASTER_HOLD_MS;
    send_sample(2'd3, 10'd1023, 1'b1, clock_ms);

    for (int i = 0; i < NUM_CHANNELS; i++) slider_pos[i] = SAMPLE_W'($urandom());

    // Random scans under several register settings, the extremes among them.
    for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
      if (phase != 0) begin
        case (phase)
          1: begin
            thr = '0;
            dly = '0;
          end
          2: begin
            thr = '1;
            dly = '1;
          end
          3: begin
            thr = THR_W'($urandom_range(1, 40));
            dly = DELAY_W'($urandom_range(0, 200));
          end
          4: begin
            thr = THRESHOLD_RESET;
            dly = ANIM_DELAY_RESET;
          end
          5: begin
            thr = THR_W'($urandom_range(0, 63));
            dly = DELAY_W'($urandom());
          end
          6: begin
            thr = 10'd2;
            dly = 16'd1;
          end
          default: begin
            thr = THR_W'($urandom_range(0, 30));
            dly = DELAY_W'($urandom_range(0, 120));
          end
        endcase
        write_settings(thr, dly);
      end
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS / NUM_SETTINGS) send_scan();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d samples in %0d scans over %0d register settings",
             items_sent, scans_sent, NUM_SETTINGS);
    $display("tb: %0d results compared, %0d with a percentage shown, %0d animation ticks",
             compared, shown, ticks);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sfmc_pkg.sv
rtl/sfmc_if.sv
rtl/sfmc_filter.sv
rtl/sfmc_scan_ctrl.sv
rtl/sfmc_queue.sv
rtl/sfmc_percent.sv
rtl/slider_filter_mode_controller.sv
rtl/sfmc_checker.sv
dv/sfmc_display_checker.sv
dv/tb.sv
